// ===== rtl/core/rfke_pkg.sv =====
// Shared constants, types and tables for the resampling filter kernel evaluator.
package rfke_pkg;

    // Bessel series limit and the counter widths that follow from it.
    localparam int MAX_SERIES_TERMS = 32;
    localparam int K_W   = $clog2(MAX_SERIES_TERMS + 1);
    localparam int I_W   = $clog2(MAX_SERIES_TERMS + 2);
    localparam int ISQ_W = 2 * I_W;

    // Kernel kinds.
    localparam logic [1:0] KIND_BOX    = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_KAISER = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;
    localparam logic [1:0] REG_INV   = 2'd3;

    // Fixed-point constants.
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] ONE_Q32    = 64'h1_0000_0000;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [63:0] BES_STOP   = 64'd4294967;
    localparam logic [39:0] SINC_SMALL = 40'd107374;

    // Request to a shared arithmetic unit.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    // Divisor (2n)(2n+1) of the n-th sine Taylor term.
    function automatic logic [8:0] taylor_div(input logic [3:0] n);
        logic [8:0] d;
        unique case (n)
            4'd1:    d = 9'd6;
            4'd2:    d = 9'd20;
            4'd3:    d = 9'd42;
            4'd4:    d = 9'd72;
            4'd5:    d = 9'd110;
            4'd6:    d = 9'd156;
            4'd7:    d = 9'd210;
            4'd8:    d = 9'd272;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/rfke_mul.sv =====
// Iterative 64x64 multiplier built on one 32x32 multiplier, four partial products.
module rfke_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfke_pkg::t_unit_req i_req,
    output logic               o_done,
    output logic [127:0]       o_prod
);
    import rfke_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;

    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shifted;

    // Select the operand halves for the current partial product.
    assign a_half = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    // Align the previous partial product.
    always_comb begin
        unique case (r_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            2'd2:    pp_shifted = {r_pp, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    // One partial product per cycle, accumulated in the cycle after it is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 3'd4);
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp  <= {32'd0, a_half} * {32'd0, b_half};
                    r_sh  <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_acc <= r_acc + pp_shifted;
                    end
                end else begin
                    r_acc  <= r_acc + pp_shifted;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/rfke_div.sv =====
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
module rfke_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfke_pkg::t_unit_req i_req,
    output logic               o_done,
    output logic [63:0]        o_quo
);
    import rfke_pkg::*;

    logic [63:0] r_rem;
    logic [63:0] r_dvd;
    logic [63:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] rem2;
    logic        ge;
    logic [64:0] diff;

    // Trial subtraction of the divisor from the shifted remainder.
    assign rem2 = {r_rem, r_dvd[63]};
    assign ge   = rem2 >= {1'b0, r_dvs};
    assign diff = rem2 - {1'b0, r_dvs};

    // Quotient bits shift into the dividend register as it empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 6'd63);
            if (i_req.start) begin
                r_rem  <= '0;
                r_dvd  <= i_req.a;
                r_dvs  <= i_req.b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[63:0] : rem2[63:0];
                r_dvd <= {r_dvd[62:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;

endmodule

// ===== rtl/core/resampling_filter_kernel_eval.sv =====
// Box, triangle and Kaiser-windowed sinc kernel evaluator, top level.
// Box and triangle results pass through ST_DECIDE and ST_OUT into the output register.
// Kaiser results also pass through the shared divider (once per Bessel series term and
// sine Taylor term), the shared multiplier and, where needed, the square root.
// Throughput: one item at a time; the next input is taken once the result is registered.
// Reset (synchronous, active low) restores register defaults and idles the sequencer.
module resampling_filter_kernel_eval (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [24:0] x_pos, [31:25] zero
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] weight
);
    import rfke_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE, ST_R_DIV, ST_RR_MUL, ST_SQRT, ST_BETA_MUL, ST_AA_MUL,
        ST_BES_CHK, ST_BES_MUL, ST_BES_DIV, ST_P_MUL, ST_SINC_T, ST_SIN_TH,
        ST_SIN_TH2, ST_TAY_MUL, ST_TAY_DIV, ST_SINC_DIV, ST_SMALL_MUL, ST_FIN_MUL,
        ST_OUT
    } t_state;

    // Configuration registers
    logic [1:0]  r_kind;
    logic [23:0] r_width;
    logic [20:0] r_beta;
    logic [40:0] r_inv;

    // Sequencer and datapath registers
    t_state      r_state;
    logic        r_wait;
    logic [24:0] r_ax;
    logic [31:0] r_r;
    logic [32:0] r_sq;
    logic [63:0] r_sn, r_sres, r_sbit;
    logic [20:0] r_a;
    logic [41:0] r_y;
    logic [63:0] r_sum, r_term, r_tmp, r_p, r_sinc;
    logic [K_W-1:0] r_k;
    logic [39:0] r_t;
    logic [16:0] r_q;
    logic        r_neg;
    logic [30:0] r_th;
    logic [31:0] r_th2, r_tterm, r_s;
    logic [3:0]  r_n;
    logic [31:0] r_w;
    logic        r_mvalid;
    logic [31:0] r_mdata;

    t_unit_req    mul_req, div_req;
    logic         mul_done, div_done;
    logic [127:0] prod;
    logic [63:0]  quo;

    logic        cfg_wr;
    logic [24:0] x_in, ax_in;
    logic [24:0] tri_diff;
    logic [15:0] sin_pm;
    logic [16:0] sin_q;
    logic [64:0] sum_ext;
    logic [I_W-1:0]   bes_i;
    logic [ISQ_W-1:0] bes_isq;
    logic [63:0] sq_try;
    logic [31:0] s_nxt, s_cl;
    logic [63:0] fin_mag, fin_neg;
    logic [63:0] small_v;

    // Shift a full product right, saturating when the result exceeds 64 bits.
    function automatic logic [63:0] sat_shr(input logic [127:0] p, input int unsigned sh);
        logic [127:0] hi;
        hi = p >> (64 + sh);
        if (hi != '0) begin
            return '1;
        end
        return 64'(p >> sh);
    endfunction

    rfke_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    rfke_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_BOX;
            r_width <= 24'd65536;
            r_beta  <= '0;
            r_inv   <= 41'h100_0000_0000;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_KIND:  r_kind  <= pwdata[1:0];
                REG_WIDTH: r_width <= pwdata[23:0];
                REG_BETA:  r_beta  <= pwdata[20:0];
                REG_INV:   r_inv   <= pwdata[40:0];
                default:   r_kind  <= r_kind;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_KIND:  prdata = 64'(r_kind);
            REG_WIDTH: prdata = 64'(r_width);
            REG_BETA:  prdata = 64'(r_beta);
            REG_INV:   prdata = 64'(r_inv);
            default:   prdata = '0;
        endcase
    end

    // Magnitude of the incoming position.
    assign x_in  = s_axis_tdata[24:0];
    assign ax_in = x_in[24] ? 25'(26'h200_0000 - {1'b0, x_in}) : x_in;

    // Miscellaneous datapath terms.
    assign tri_diff = {1'b0, r_width} - r_ax;
    assign sin_pm   = r_ax[15:0];
    assign sin_q    = (sin_pm > 16'h8000) ? 17'(18'h1_0000 - {2'b0, sin_pm})
                                          : {1'b0, sin_pm};
    assign sum_ext  = {1'b0, r_sum} + {1'b0, r_term};
    assign bes_i    = I_W'(r_k) + I_W'(1);
    assign bes_isq  = ISQ_W'(bes_i) * ISQ_W'(bes_i);
    assign sq_try   = r_sres + r_sbit;
    assign small_v  = 64'(prod >> 30);
    assign fin_mag  = sat_shr(prod, 38);
    assign fin_neg  = 64'd0 - fin_mag;

    // Next Taylor partial sum and its clamp to 1.0.
    always_comb begin
        if (r_n[0]) begin
            s_nxt = (r_s >= quo[31:0]) ? (r_s - quo[31:0]) : 32'd0;
        end else begin
            s_nxt = r_s + quo[31:0];
        end
        s_cl = (s_nxt > ONE_Q30) ? ONE_Q30 : s_nxt;
    end

    // Multiplier operands by state.
    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (r_state)
            ST_RR_MUL:    begin mul_req.a = 64'(r_r);     mul_req.b = 64'(r_r);   end
            ST_BETA_MUL:  begin mul_req.a = 64'(r_beta);  mul_req.b = 64'(r_sq);  end
            ST_AA_MUL:    begin mul_req.a = 64'(r_a);     mul_req.b = 64'(r_a);   end
            ST_BES_MUL:   begin mul_req.a = r_term;       mul_req.b = 64'(r_y);   end
            ST_P_MUL:     begin mul_req.a = r_sum;        mul_req.b = 64'(r_inv); end
            ST_SINC_T:    begin mul_req.a = PI_Q30;       mul_req.b = 64'(r_ax);  end
            ST_SIN_TH:    begin mul_req.a = PI_Q30;       mul_req.b = 64'(r_q);   end
            ST_SIN_TH2:   begin mul_req.a = 64'(r_th);    mul_req.b = 64'(r_th);  end
            ST_TAY_MUL:   begin mul_req.a = 64'(r_tterm); mul_req.b = 64'(r_th2); end
            ST_SMALL_MUL: begin mul_req.a = 64'(r_t);     mul_req.b = 64'(r_t);   end
            ST_FIN_MUL:   begin mul_req.a = r_sinc;       mul_req.b = r_p;        end
            default:      begin mul_req.a = '0;           mul_req.b = '0;         end
        endcase
        mul_req.start = !r_wait && (r_state == ST_RR_MUL || r_state == ST_BETA_MUL ||
                        r_state == ST_AA_MUL || r_state == ST_BES_MUL ||
                        r_state == ST_P_MUL || r_state == ST_SINC_T ||
                        r_state == ST_SIN_TH || r_state == ST_SIN_TH2 ||
                        r_state == ST_TAY_MUL || r_state == ST_SMALL_MUL ||
                        r_state == ST_FIN_MUL);
    end

    // Divider operands by state.
    always_comb begin
        unique case (r_state)
            ST_R_DIV:    begin div_req.a = {7'd0, r_ax, 32'd0};   div_req.b = 64'(r_width); end
            ST_BES_DIV:  begin div_req.a = r_tmp;                 div_req.b = 64'(bes_isq); end
            ST_TAY_DIV:  begin div_req.a = r_tmp;       div_req.b = 64'(taylor_div(r_n)); end
            ST_SINC_DIV: begin div_req.a = 64'({r_s, 30'd0});     div_req.b = 64'(r_t);     end
            default:     begin div_req.a = '0;                    div_req.b = '0;           end
        endcase
        div_req.start = !r_wait && (r_state == ST_R_DIV || r_state == ST_BES_DIV ||
                        r_state == ST_TAY_DIV || r_state == ST_SINC_DIV);
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_mvalid <= 1'b0;
            r_k      <= '0;
            r_n      <= '0;
        end else begin
            if (r_state == ST_OUT && (!r_mvalid || m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ax    <= ax_in;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    unique case (r_kind)
                        KIND_BOX: begin
                            r_w     <= (r_ax <= {1'b0, r_width}) ? 32'h0100_0000 : 32'd0;
                            r_state <= ST_OUT;
                        end
                        KIND_TRI: begin
                            if (r_ax > {1'b0, r_width}) begin
                                r_w <= '0;
                            end else if (tri_diff[23]) begin
                                r_w <= 32'h7FFF_FFFF;
                            end else begin
                                r_w <= {tri_diff[23:0], 8'd0};
                            end
                            r_state <= ST_OUT;
                        end
                        KIND_KAISER: begin
                            if (r_width != '0 && r_ax < {1'b0, r_width}) begin
                                r_state <= ST_R_DIV;
                            end else begin
                                r_w     <= '0;
                                r_state <= ST_OUT;
                            end
                        end
                        default: begin
                            r_w     <= '0;
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_R_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait  <= 1'b0;
                        r_r     <= quo[31:0];
                        r_state <= ST_RR_MUL;
                    end
                end
                ST_RR_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (prod[127:32] == '0) begin
                            r_sq    <= 33'h1_0000_0000;
                            r_state <= ST_BETA_MUL;
                        end else begin
                            r_sn    <= {32'(ONE_Q32 - 64'(prod[127:32])), 32'd0};
                            r_sres  <= '0;
                            r_sbit  <= 64'h4000_0000_0000_0000;
                            r_state <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    // One result bit per cycle.
                    if (r_sn >= sq_try) begin
                        r_sn   <= r_sn - sq_try;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit == 64'd1) begin
                        r_sq    <= (r_sn >= sq_try) ? 33'((r_sres >> 1) + r_sbit)
                                                    : 33'(r_sres >> 1);
                        r_state <= ST_BETA_MUL;
                    end
                end
                ST_BETA_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_a     <= prod[52:32];
                        r_state <= ST_AA_MUL;
                    end
                end
                ST_AA_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_y     <= prod[43:2];
                        r_term  <= 64'(prod[43:2]);
                        r_sum   <= ONE_Q32;
                        r_k     <= '0;
                        r_state <= ST_BES_CHK;
                    end
                end
                ST_BES_CHK: begin
                    if (r_term > BES_STOP && r_k < K_W'(MAX_SERIES_TERMS)) begin
                        r_sum   <= sum_ext[64] ? '1 : sum_ext[63:0];
                        r_k     <= r_k + K_W'(1);
                        r_state <= ST_BES_MUL;
                    end else begin
                        r_state <= ST_P_MUL;
                    end
                end
                ST_BES_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= sat_shr(prod, 32);
                        r_state <= ST_BES_DIV;
                    end
                end
                ST_BES_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait  <= 1'b0;
                        r_term  <= quo;
                        r_state <= ST_BES_CHK;
                    end
                end
                ST_P_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_p     <= sat_shr(prod, 40);
                        r_state <= ST_SINC_T;
                    end
                end
                ST_SINC_T: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        r_t    <= prod[55:16];
                        if (prod[55:16] < SINC_SMALL) begin
                            r_neg   <= 1'b0;
                            r_state <= ST_SMALL_MUL;
                        end else begin
                            r_neg   <= r_ax[16];
                            r_q     <= sin_q;
                            r_state <= ST_SIN_TH;
                        end
                    end
                end
                ST_SIN_TH: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_th    <= prod[46:16];
                        r_state <= ST_SIN_TH2;
                    end
                end
                ST_SIN_TH2: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_th2   <= prod[61:30];
                        r_tterm <= 32'(r_th);
                        r_s     <= 32'(r_th);
                        r_n     <= 4'd1;
                        r_state <= ST_TAY_MUL;
                    end
                end
                ST_TAY_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= 64'(prod >> 30);
                        r_state <= ST_TAY_DIV;
                    end
                end
                ST_TAY_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait  <= 1'b0;
                        r_tterm <= quo[31:0];
                        if (r_n == 4'd8) begin
                            r_s <= s_cl;
                            if (s_cl == '0) begin
                                r_neg <= 1'b0;
                            end
                            r_state <= ST_SINC_DIV;
                        end else begin
                            r_s     <= s_nxt;
                            r_n     <= r_n + 4'd1;
                            r_state <= ST_TAY_MUL;
                        end
                    end
                end
                ST_SINC_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait  <= 1'b0;
                        r_sinc  <= quo;
                        r_state <= ST_FIN_MUL;
                    end
                end
                ST_SMALL_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        // The squared term stays below 12, so its sixth is 0 or 1.
                        r_wait  <= 1'b0;
                        r_sinc  <= (small_v >= 64'd6) ? 64'(ONE_Q30 - 32'd1)
                                                      : 64'(ONE_Q30);
                        r_state <= ST_FIN_MUL;
                    end
                end
                ST_FIN_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_neg) begin
                            r_w <= (fin_mag > 64'h8000_0000) ? 32'h8000_0000 : fin_neg[31:0];
                        end else begin
                            r_w <= (fin_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : fin_mag[31:0];
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mdata  <= r_w;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // The shared units are never started in the same cycle.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");

    // An accepted input transaction makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // The series counter never exceeds its limit.
    a_series_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= K_W'(MAX_SERIES_TERMS))
        else $error("Bessel series ran past its term limit");

    // A unit only reports completion while the sequencer waits for it.
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> r_wait)
        else $error("arithmetic unit finished with no pending request");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the resampling filter kernel evaluator.
module tb_top;
    import rfke_pkg::*;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 20000000;
    localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [24:0] x_pos, [31:25] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] weight

    // Local copy of the configuration registers.
    logic [1:0]  cur_kind  = KIND_BOX;
    logic [23:0] cur_width = 24'd65536;
    logic [20:0] cur_beta  = '0;
    logic [40:0] cur_inv   = 41'h100_0000_0000;

    logic [31:0] weight_q[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    resampling_filter_kernel_eval u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Fixed-point helpers of the kernel math.
    function automatic logic [63:0] mul_shift_sat(input logic [63:0] a, input logic [63:0] b,
                                                  input int sh);
        logic [127:0] prod;
        logic [127:0] shifted;
        prod = {64'd0, a} * {64'd0, b};
        shifted = prod >> sh;
        if (shifted[127:64] != 0)
            return '1;
        return shifted[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Modified Bessel I0 of a Q5.16 argument, Q.32 result.
    function automatic logic [63:0] bessel_sum(input logic [63:0] a);
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] idx;
        logic [64:0] wide;
        int added;
        y = (a * a) >> 2;
        sum = ONE_Q32;
        term = y;
        idx = 2;
        added = 0;
        while (term > BES_STOP && added < MAX_SERIES_TERMS) begin
            wide = {1'b0, sum} + {1'b0, term};
            sum = wide[64] ? '1 : wide[63:0];
            added++;
            term = mul_shift_sat(term, y, 32) / (idx * idx);
            idx++;
        end
        return sum;
    endfunction

    // Magnitude of sinc(pi*ax) in Q.30; the sign comes back in neg.
    function automatic logic [63:0] sinc_mag(input logic [63:0] ax, output bit neg);
        logic [63:0] t;
        logic [63:0] ph;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] s;
        neg = 1'b0;
        t = (PI_Q30 * ax) >> 16;
        if (t < SINC_SMALL)
            return ONE_Q30 - ((t * t) >> 30) / 6;
        // Reduce modulo 2.0 and fold into the first quarter wave.
        ph = ax & 64'h1FFFF;
        if (ph >= 64'h10000) begin
            neg = 1'b1;
            ph = ph - 64'h10000;
        end
        if (ph > 64'h8000)
            ph = 64'h10000 - ph;
        th = (PI_Q30 * ph) >> 16;
        th2 = (th * th) >> 30;
        term = th;
        s = th;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                s = (s >= term) ? s - term : 0;
            else
                s = s + term;
        end
        if (s > ONE_Q30)
            s = ONE_Q30;
        if (s == 0)
            neg = 1'b0;
        return (s << 30) / t;
    endfunction

    function automatic logic [31:0] kaiser_at(input logic [63:0] ax);
        logic [63:0] wd;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] sq;
        logic [63:0] a;
        logic [63:0] p;
        logic [63:0] mag;
        logic [63:0] sn;
        bit neg;
        wd = 64'(cur_width);
        if (wd == 0 || ax >= wd)
            return 32'd0;
        r = (ax << 32) / wd;
        u = ONE_Q32 - ((r * r) >> 32);
        sq = (u >= ONE_Q32) ? ONE_Q32 : int_sqrt(u << 32);
        a = (64'(cur_beta) * sq) >> 32;
        p = mul_shift_sat(bessel_sum(a), 64'(cur_inv), 40);
        sn = sinc_mag(ax, neg);
        mag = mul_shift_sat(sn, p, 38);
        if (neg) begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'((64'd0 - mag) & LOW32);
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Kernel weight, Q8.24, for one position under the current settings.
    function automatic logic [31:0] kernel_weight(input logic [24:0] x);
        logic [63:0] ax;
        logic [63:0] w;
        ax = x[24] ? 64'(26'h200_0000 - {1'b0, x}) : 64'(x);
        w = 0;
        case (cur_kind)
            KIND_BOX: begin
                w = (ax <= 64'(cur_width)) ? 64'd1 << 24 : 0;
            end
            KIND_TRI: begin
                if (ax <= 64'(cur_width)) begin
                    w = (64'(cur_width) - ax) << 8;
                    if (w > 64'h7FFF_FFFF)
                        w = 64'h7FFF_FFFF;
                end
            end
            KIND_KAISER: begin
                w = 64'(kaiser_at(ax));
            end
            default: begin
                w = 0;
            end
        endcase
        return w[31:0];
    endfunction

    // Result checking and random back-pressure on the output side.
    always @(posedge i_clk) begin
        logic [31:0] want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (weight_q.size() == 0) begin
                $error("weight: no transaction expected, actual %0d",
                       $signed(m_axis_tdata));
                mismatches++;
            end else begin
                want = weight_q.pop_front();
                if (want !== m_axis_tdata) begin
                    $error("weight: expected %0d, actual %0d", $signed(want),
                           $signed(m_axis_tdata));
                    mismatches++;
                end
            end
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (weight_q.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle, once nothing is in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KIND:  cur_kind = val[1:0];
            REG_WIDTH: cur_width = val[23:0];
            REG_BETA:  cur_beta = val[20:0];
            default:   cur_inv = val[40:0];
        endcase
    endtask

    task automatic configure(input logic [1:0] kind, input logic [23:0] width,
                             input logic [20:0] beta, input logic [40:0] inv);
        write_reg(REG_KIND, 64'(kind));
        write_reg(REG_WIDTH, 64'(width));
        write_reg(REG_BETA, 64'(beta));
        write_reg(REG_INV, 64'(inv));
    endtask

    // Send one position; the expected weight is queued at acceptance.
    task automatic send_x(input logic [24:0] x);
        if (!calm && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, x};
        do @(posedge i_clk); while (!s_axis_tready);
        weight_q.push_back(kernel_weight(x));
    endtask

    task automatic test_box();
        send_x(25'd0);
        send_x(25'd65536);
        send_x(-25'sd65536);
        send_x(25'd65537);
        send_x(25'h0FF_FFFF);
        send_x(25'h100_0000);
        wait_drained();
    endtask

    task automatic test_triangle();
        configure(KIND_TRI, 24'd98304, 21'd0, 41'h100_0000_0000);
        send_x(25'd0);
        send_x(-25'sd32768);
        send_x(25'd98305);
        // Widest kernel at the center overflows Q8.24.
        configure(KIND_TRI, 24'hFF_FFFF, 21'd0, 41'h100_0000_0000);
        send_x(25'd0);
        send_x(25'h100_0000);
        wait_drained();
    endtask

    task automatic test_kaiser();
        configure(KIND_KAISER, 24'd196608, 21'd393216, 41'd19_000_000_000);
        send_x(25'd0);
        send_x(25'd1);      // tiny argument takes the short sinc form
        send_x(-25'sd2);
        send_x(25'd98304);
        send_x(-25'sd163840);
        send_x(25'd196608);
        wait_drained();
        // Out-of-range beta and reciprocal drive the weight into saturation.
        configure(KIND_KAISER, 24'hFF_FFFF, 21'h1F_FFFF, 41'h1FF_FFFF_FFFF);
        send_x(25'd3);
        send_x(25'd98304);
        wait_drained();
    endtask

    task automatic test_odd_settings();
        configure(KIND_UNKNOWN, 24'd65536, 21'd0, 41'd0);
        send_x(25'd0);
        configure(KIND_BOX, 24'd0, 21'd0, 41'd0);
        send_x(25'd0);
        send_x(25'd1);
        write_reg(REG_KIND, 64'(KIND_TRI));
        send_x(25'd0);
        write_reg(REG_KIND, 64'(KIND_KAISER));
        send_x(25'd0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [1:0]  kind;
        logic [23:0] width;
        logic [20:0] beta;
        logic [40:0] inv;
        logic [24:0] x;
        int unsigned mag;
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = KIND_BOX;
                3, 4, 5: kind = KIND_TRI;
                6, 7, 8: kind = KIND_KAISER;
                default: kind = KIND_UNKNOWN;
            endcase
            case ($urandom_range(0, 5))
                0:       width = 24'hFF_FFFF;
                1:       width = 24'd0;
                2:       width = 24'($urandom_range(1, 24'hFF_FFFF));
                default: width = 24'($urandom_range(1, 24'h8_0000));
            endcase
            beta = ($urandom_range(0, 7) == 0) ? 21'h1F_FFFF
                                               : 21'($urandom_range(0, 1048576));
            case ($urandom_range(0, 5))
                0:       inv = 41'h1FF_FFFF_FFFF;
                1:       inv = 41'h100_0000_0000;
                default: inv = {9'd0, $urandom} | (41'($urandom_range(0, 255)) << 32);
            endcase
            configure(kind, width, beta, inv);
            calm = (ph == 4);
            for (int n = 0; n < 50; n++) begin
                // Most positions fall inside the kernel, the rest anywhere.
                if ($urandom_range(0, 9) < 7) begin
                    mag = $urandom_range(0, width);
                    x = $urandom_range(0, 1) ? -25'(mag) : 25'(mag);
                end else begin
                    x = 25'($urandom);
                end
                send_x(x);
                if (n == 25)
                    wait_drained();
            end
            wait_drained();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_box();
        test_triangle();
        test_kaiser();
        test_odd_settings();
        test_random();
        wait_drained();
        repeat (4000) @(posedge i_clk);
        if (mismatches == 0 && weight_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rfke_pkg.sv
rtl/core/rfke_mul.sv
rtl/core/rfke_div.sv
rtl/core/resampling_filter_kernel_eval.sv
bench/tb_top.sv
